// ===== hdl/ogrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ogrc_pkg
// Shared types and constants of the occupancy grid range count unit.
// ----------------------------------------------------------------------------
package ogrc_pkg;

   // grid limits
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   // cell index widths and corner/dimension widths (0..MAX inclusive)
   localparam int X_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int Y_BITS    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CX_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int CY_BITS   = $clog2(MAX_HEIGHT + 1);
   localparam int ADDR_BITS = X_BITS + Y_BITS;
   localparam int MEM_DEPTH = 2 ** ADDR_BITS;

   // field widths
   localparam int CFG_BITS   = 9;
   localparam int COORD_BITS = 16;
   localparam int FUNC_BITS  = 2;
   localparam int COUNT_BITS = 17;

   // stream and register port widths
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 24;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // function codes
   localparam logic [FUNC_BITS-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_COUNT = 2'd2;

   // register indexes
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // result source selected by the controller
   typedef enum logic [1:0] {
      RES_ZERO  = 2'd0,
      RES_ERROR = 2'd1,
      RES_CELL  = 2'd2,
      RES_COUNT = 2'd3
   } res_type;

   typedef struct packed {
      logic    capture;
      logic    clr_step;
      logic    cell_write;
      logic    reb_start;
      logic    reb_read;
      logic    reb_write;
      logic    qry_start;
      logic    qry_step;
      logic    rsp_load;
      res_type res_src;
   } ogrc_cmd_type;

   typedef struct packed {
      logic                 clear_last;
      logic [FUNC_BITS-1:0] func;
      logic                 in_grid;
      logic                 empty_range;
      logic                 stale;
      logic                 reb_last;
      logic                 qry_last;
   } ogrc_status_type;

endpackage

// ===== hdl/occupancy_grid_range_count_unit.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_range_count_unit
// Binary occupancy grid with a summed-area table for rectangle counts.
//
//   port group   direction   payload
//   req_*        in          tuser: func; tdata: x_low, y_low, x_high, y_high, cell_value
//   rsp_*        out         tuser: status; tdata: hit_count, any_occupied
//   csr_*        in/out      grid_width at 0x0, grid_height at 0x4
//
// An item occupies the unit from acceptance until its result is loaded into
// the output register. Write, read, empty counts and other function codes go
// straight from decode to hand-off; a count on a fresh table makes four reads
// through the table port. A count on a stale table first rebuilds the table,
// one cell at a time, a read state then a write state per cell through the grid
// and table memories. After reset a clearing pass zeroes the grid, req_tready low.
// The next item is taken while a result waits on rsp_tready; a stalled result
// holds the unit in its hand-off state.
// ----------------------------------------------------------------------------
module occupancy_grid_range_count_unit
   import ogrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [15:0] x_low, [31:16] y_low, [47:32] x_high, [63:48] y_high, [64] cell_value
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] func
   input  logic [FUNC_BITS-1:0]     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [16:0] hit_count, [17] any_occupied
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // [0] status
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   ogrc_cmd_type    cmd;
   ogrc_status_type status;

   assign csr_pready = 1'b1;

   ogrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   ogrc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata)
   );

endmodule

// ===== hdl/ogrc_ram.sv =====
// ----------------------------------------------------------------------------
// ogrc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ogrc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ogrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ogrc_ctrl
// Controller: sequences clearing, cell access, table rebuild, range query
// and result hand-off.
// ----------------------------------------------------------------------------
module ogrc_ctrl
   import ogrc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   input  ogrc_status_type status,
   output ogrc_cmd_type    cmd
);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_DECODE = 8'b0000_0100,
      S_REB_RD = 8'b0000_1000,
      S_REB_WR = 8'b0001_0000,
      S_QRY    = 8'b0010_0000,
      S_RESP   = 8'b0100_0000,
      S_SPARE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   res_type   src_ff, src_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      cmd          = '0;
      cmd.res_src  = src_ff;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESP;
            src_in   = RES_ZERO;
            case (status.func)
               FUNC_WRITE: begin
                  if (status.in_grid) begin
                     cmd.cell_write = 1'b1;
                  end else begin
                     src_in = RES_ERROR;
                  end
               end
               FUNC_READ: begin
                  if (status.in_grid) begin
                     src_in = RES_CELL;
                  end
               end
               FUNC_COUNT: begin
                  if (!status.empty_range) begin
                     if (status.stale) begin
                        cmd.reb_start = 1'b1;
                        state_in      = S_REB_RD;
                     end else begin
                        cmd.qry_start = 1'b1;
                        state_in      = S_QRY;
                     end
                  end
               end
               default: begin
                  src_in = RES_ZERO;
               end
            endcase
         end
         S_REB_RD: begin
            cmd.reb_read = 1'b1;
            state_in     = S_REB_WR;
         end
         S_REB_WR: begin
            cmd.reb_write = 1'b1;
            if (status.reb_last) begin
               cmd.qry_start = 1'b1;
               state_in      = S_QRY;
            end else begin
               state_in = S_REB_RD;
            end
         end
         S_QRY: begin
            cmd.qry_step = 1'b1;
            if (status.qry_last) begin
               src_in   = RES_COUNT;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         src_ff       <= RES_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hdl/ogrc_dpath.sv =====
// ----------------------------------------------------------------------------
// ogrc_dpath
// Datapath: grid and table memories, dimension registers, item registers,
// rebuild counters, query accumulator and result registers.
// ----------------------------------------------------------------------------
module ogrc_dpath
   import ogrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ogrc_cmd_type             cmd,
   output ogrc_status_type          status,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic [FUNC_BITS-1:0]     req_tuser,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tuser,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata
);

   // clamp a signed coordinate into 0..dim-1
   function automatic int clamp_index(input logic signed [COORD_BITS-1:0] v, input int dim);
      int vi;
      vi = int'(v);
      if (vi < 0) begin
         return 0;
      end else if (vi >= dim) begin
         return dim - 1;
      end
      return vi;
   endfunction

   // registers
   logic [CFG_BITS-1:0]          width_reg_ff, height_reg_ff;
   logic                         table_valid_ff, table_valid_in;
   logic [FUNC_BITS-1:0]         func_ff;
   logic signed [COORD_BITS-1:0] xl_ff, yl_ff, xh_ff, yh_ff;
   logic                         val_ff;
   logic [ADDR_BITS-1:0]         clr_ff;
   logic [X_BITS-1:0]            rx_ff, rx_in;
   logic [Y_BITS-1:0]            ry_ff, ry_in;
   logic [CX_BITS-1:0]           rowsum_ff, rowsum_in;
   logic [2:0]                   q_ff;
   logic                         sub_ff, sub_in;
   logic                         zero_ff, zero_in;
   logic [COUNT_BITS-1:0]        acc_ff, acc_in;
   logic [COUNT_BITS-1:0]        count_ff;
   logic                         any_ff, status_ff;

   // combinational
   logic [CX_BITS-1:0]     grid_w, grid_w_m1, x0c, x1c, cx;
   logic [CY_BITS-1:0]     grid_h, grid_h_m1, y0c, y1c, cy;
   logic                   csr_wr;
   logic [ADDR_BITS-1:0]   cell_addr, reb_addr, corner_addr;
   logic                   occ_we, occ_wdata, occ_rdata;
   logic [ADDR_BITS-1:0]   occ_waddr, occ_raddr;
   logic                   pfx_we;
   logic [ADDR_BITS-1:0]   pfx_raddr;
   logic [COUNT_BITS-1:0]  pfx_wdata, pfx_rdata, above, term;
   logic                   row_end;

   // saturated grid size
   always_comb begin
      if (width_reg_ff == '0) begin
         grid_w = CX_BITS'(1);
      end else if (int'(width_reg_ff) > MAX_WIDTH) begin
         grid_w = CX_BITS'(MAX_WIDTH);
      end else begin
         grid_w = CX_BITS'(width_reg_ff);
      end
      if (height_reg_ff == '0) begin
         grid_h = CY_BITS'(1);
      end else if (int'(height_reg_ff) > MAX_HEIGHT) begin
         grid_h = CY_BITS'(MAX_HEIGHT);
      end else begin
         grid_h = CY_BITS'(height_reg_ff);
      end
      grid_w_m1 = grid_w - CX_BITS'(1);
      grid_h_m1 = grid_h - CY_BITS'(1);
   end

   // configuration registers
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff  <= CFG_BITS'(256);
         height_reg_ff <= CFG_BITS'(256);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_GRID_WIDTH:  width_reg_ff  <= csr_pwdata[CFG_BITS-1:0];
            REG_GRID_HEIGHT: height_reg_ff <= csr_pwdata[CFG_BITS-1:0];
            default:         width_reg_ff  <= width_reg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_GRID_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_reg_ff);
         REG_GRID_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_reg_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // item registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_tuser;
         xl_ff   <= req_tdata[15:0];
         yl_ff   <= req_tdata[31:16];
         xh_ff   <= req_tdata[47:32];
         yh_ff   <= req_tdata[63:48];
         val_ff  <= req_tdata[64];
      end
   end

   // corners: low corner clamped, high corner clamped plus one
   always_comb begin
      x0c = CX_BITS'(clamp_index(xl_ff, int'(grid_w)));
      y0c = CY_BITS'(clamp_index(yl_ff, int'(grid_h)));
      x1c = CX_BITS'(clamp_index(xh_ff, int'(grid_w))) + CX_BITS'(1);
      y1c = CY_BITS'(clamp_index(yh_ff, int'(grid_h))) + CY_BITS'(1);
   end

   assign cell_addr = {yl_ff[Y_BITS-1:0], xl_ff[X_BITS-1:0]};
   assign reb_addr  = {ry_ff, rx_ff};

   // occupancy memory: clear pass, cell writes, cell and rebuild reads
   always_comb begin
      occ_we    = cmd.clr_step | cmd.cell_write;
      occ_waddr = cmd.clr_step ? clr_ff : cell_addr;
      occ_wdata = cmd.clr_step ? 1'b0 : val_ff;
      occ_raddr = cmd.reb_read ? reb_addr : cell_addr;
   end

   ogrc_ram #(
      .WIDTH(1),
      .DEPTH(MEM_DEPTH)
   ) u_occ_ram (
      .clock  (clock),
      .wr_en  (occ_we),
      .wr_addr(occ_waddr),
      .wr_data(occ_wdata),
      .rd_addr(occ_raddr),
      .rd_data(occ_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + ADDR_BITS'(1);
      end
   end

   // corner select; row 0 and column 0 of the table are always zero
   always_comb begin
      cx      = x1c;
      cy      = y1c;
      sub_in  = 1'b0;
      case (q_ff[1:0])
         2'd0: begin
            cx = x1c;
            cy = y1c;
         end
         2'd1: begin
            cx     = x0c;
            cy     = y1c;
            sub_in = 1'b1;
         end
         2'd2: begin
            cx     = x1c;
            cy     = y0c;
            sub_in = 1'b1;
         end
         default: begin
            cx = x0c;
            cy = y0c;
         end
      endcase
      zero_in     = (cx == '0) || (cy == '0);
      corner_addr = {Y_BITS'(cy - CY_BITS'(1)), X_BITS'(cx - CX_BITS'(1))};
   end

   // table memory: entry (x,y) of the summed-area table sits at {y-1, x-1}
   always_comb begin
      pfx_raddr = cmd.reb_read ? {Y_BITS'(ry_ff - Y_BITS'(1)), rx_ff} : corner_addr;
      above     = (ry_ff == '0) ? '0 : pfx_rdata;
      rowsum_in = rowsum_ff + CX_BITS'(occ_rdata);
      pfx_wdata = above + COUNT_BITS'(rowsum_in);
      pfx_we    = cmd.reb_write;
   end

   ogrc_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(MEM_DEPTH)
   ) u_pfx_ram (
      .clock  (clock),
      .wr_en  (pfx_we),
      .wr_addr(reb_addr),
      .wr_data(pfx_wdata),
      .rd_addr(pfx_raddr),
      .rd_data(pfx_rdata)
   );

   // rebuild walk, row by row
   always_comb begin
      row_end = ({1'b0, rx_ff} == grid_w_m1);
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      if (cmd.reb_start) begin
         rx_in = '0;
         ry_in = '0;
      end else if (cmd.reb_write) begin
         if (row_end) begin
            rx_in = '0;
            ry_in = ry_ff + Y_BITS'(1);
         end else begin
            rx_in = rx_ff + X_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      if (cmd.reb_start || (cmd.reb_write && row_end)) begin
         rowsum_ff <= '0;
      end else if (cmd.reb_write) begin
         rowsum_ff <= rowsum_in;
      end
   end

   // table freshness
   always_comb begin
      table_valid_in = table_valid_ff;
      if (csr_wr || cmd.cell_write) begin
         table_valid_in = 1'b0;
      end else if (cmd.reb_write && status.reb_last) begin
         table_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_valid_ff <= 1'b0;
      end else begin
         table_valid_ff <= table_valid_in;
      end
   end

   // query: four reads, each accumulated in the cycle after its read
   always_comb begin
      term   = zero_ff ? '0 : pfx_rdata;
      acc_in = acc_ff;
      if (cmd.qry_start) begin
         acc_in = '0;
      end else if (cmd.qry_step && q_ff != 3'd0) begin
         acc_in = sub_ff ? (acc_ff - term) : (acc_ff + term);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.qry_start) begin
         q_ff <= '0;
      end else if (cmd.qry_step) begin
         q_ff <= q_ff + 3'd1;
      end
      sub_ff  <= sub_in;
      zero_ff <= zero_in;
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         count_ff  <= '0;
         any_ff    <= 1'b0;
         status_ff <= 1'b0;
         case (cmd.res_src)
            RES_ERROR: status_ff <= 1'b1;
            RES_CELL:  any_ff    <= occ_rdata;
            RES_COUNT: begin
               count_ff <= acc_ff;
               any_ff   <= (acc_ff != '0);
            end
            default:   status_ff <= 1'b0;
         endcase
      end
   end

   assign rsp_tdata = {{(RSP_DATA_BITS - COUNT_BITS - 1){1'b0}}, any_ff, count_ff};
   assign rsp_tuser = status_ff;

   // status toward the controller
   always_comb begin
      status.clear_last  = &clr_ff;
      status.func        = func_ff;
      status.in_grid     = (int'(xl_ff) >= 0) && (int'(xl_ff) < int'(grid_w)) &&
                           (int'(yl_ff) >= 0) && (int'(yl_ff) < int'(grid_h));
      status.empty_range = (xh_ff < xl_ff) || (yh_ff < yl_ff);
      status.stale       = ~table_valid_ff;
      status.reb_last    = row_end && ({1'b0, ry_ff} == grid_h_m1);
      status.qry_last    = (q_ff == 3'd4);
   end

endmodule

// ===== hdl/ogrc_checker.sv =====
// ----------------------------------------------------------------------------
// ogrc_checker
// Port-level checks on the occupancy grid range count unit.
// ----------------------------------------------------------------------------
module ogrc_checker
   import ogrc_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tuser
);

   // no item taken and no result shown during the clearing pass start
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("unit active right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a refused write carries no count
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[COUNT_BITS:0] == '0)
      else $error("error result with nonzero payload");

   a_any_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[COUNT_BITS-1:0] != '0) |-> rsp_tdata[COUNT_BITS])
      else $error("nonzero count without any_occupied");

endmodule

bind occupancy_grid_range_count_unit ogrc_checker u_ogrc_checker (.*);
